[sv/utf8lt_pkg.sv]
// Shared types and constants for the UTF-8 decoder with line tracking.
package utf8lt_pkg;

    localparam int unsigned CP_W = 21;

    // Lead byte thresholds
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;

    // Line control characters and the end marker value
    localparam logic [CP_W-1:0] CP_LF  = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR  = 21'h00000D;
    localparam logic [CP_W-1:0] CP_END = 21'h1FFFFF;

    // Register index decoded from the APB address
    localparam logic REG_FIRST_LINE = 1'b0;
    localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

    // One queued request from the decode side to the line tracker
    typedef struct packed {
        logic            has_char;
        logic            has_end;
        logic [CP_W-1:0] codepoint;
    } q_entry_t;

endpackage

[sv/utf8lt_front.sv]
// Byte-level UTF-8 sequence assembly; pushes finished characters and end markers.
module utf8lt_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 q_full,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_input,
    output logic                 push,
    output utf8lt_pkg::q_entry_t push_entry
);

    logic [1:0]                  pending_reg;
    logic [1:0]                  pending_next;
    logic [utf8lt_pkg::CP_W-1:0] acc_reg;
    logic [utf8lt_pkg::CP_W-1:0] acc_next;
    logic [utf8lt_pkg::CP_W-1:0] acc_fill;
    logic [utf8lt_pkg::CP_W-1:0] acc_shift;
    logic                        accept;

    assign accept = in_valid && !q_full;

    // Pad a cut-off sequence with 0x3F continuation payloads
    always_comb
    begin
        unique case (pending_reg)
            2'd1:    acc_fill = {acc_reg[14:0], 6'h3F};
            2'd2:    acc_fill = {acc_reg[8:0], 12'hFFF};
            2'd3:    acc_fill = {acc_reg[2:0], 18'h3FFFF};
            default: acc_fill = acc_reg;
        endcase
    end

    assign acc_shift = {acc_reg[14:0], data_byte[5:0]};

    // Classify the byte and decide what to push
    always_comb
    begin
        pending_next         = pending_reg;
        acc_next             = acc_reg;
        push                 = 1'b0;
        push_entry.has_char  = 1'b0;
        push_entry.has_end   = 1'b0;
        push_entry.codepoint = acc_shift;
        if (accept)
        begin
            priority if (end_of_input)
            begin
                push                 = 1'b1;
                push_entry.has_end   = 1'b1;
                push_entry.has_char  = (pending_reg != 2'd0);
                push_entry.codepoint = acc_fill;
                pending_next         = 2'd0;
                acc_next             = '0;
            end
            else if (pending_reg != 2'd0)
            begin
                pending_next = pending_reg - 2'd1;
                acc_next     = acc_shift;
                if (pending_reg == 2'd1)
                begin
                    push                = 1'b1;
                    push_entry.has_char = 1'b1;
                    acc_next            = '0;
                end
            end
            else if (data_byte < utf8lt_pkg::LEAD2_MIN)
            begin
                push                 = 1'b1;
                push_entry.has_char  = 1'b1;
                push_entry.codepoint = {13'd0, data_byte};
            end
            else if (data_byte < utf8lt_pkg::LEAD3_MIN)
            begin
                acc_next     = {16'd0, data_byte[4:0]};
                pending_next = 2'd1;
            end
            else if (data_byte < utf8lt_pkg::LEAD4_MIN)
            begin
                acc_next     = {17'd0, data_byte[3:0]};
                pending_next = 2'd2;
            end
            else
            begin
                acc_next     = {18'd0, data_byte[2:0]};
                pending_next = 2'd3;
            end
        end
    end

    // Hold sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            acc_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

[sv/utf8lt_fifo.sv]
// Four-entry request queue between the decode side and the line tracker.
module utf8lt_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utf8lt_pkg::q_entry_t push_entry,
    input  logic                 pop,
    output utf8lt_pkg::q_entry_t head,
    output logic                 empty,
    output logic                 full
);

    utf8lt_pkg::q_entry_t mem_reg [4];
    logic [1:0]           wr_ptr_reg;
    logic [1:0]           rd_ptr_reg;
    logic [2:0]           count_reg;
    logic [2:0]           count_next;

    assign empty = (count_reg == 3'd0);
    assign full  = (count_reg == 3'd4);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[sv/utf8lt_back.sv]
// Line-start tracking and the registered result stage.
module utf8lt_back
#(
    parameter int unsigned POS_BITS  = 32,
    parameter int unsigned LINE_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  utf8lt_pkg::q_entry_t        head,
    input  logic                        q_empty,
    output logic                        pop,
    input  logic                        cfg_load,
    input  logic [15:0]                 cfg_first_line,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [utf8lt_pkg::CP_W-1:0] codepoint,
    output logic                        is_end,
    output logic                        line_start_valid,
    output logic [31:0]                 line_start_pos,
    output logic [31:0]                 line_start_number,
    output logic                        last
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 phase_reg;
    logic                 phase_next;
    logic [POS_BITS-1:0]  pos_reg;
    logic [POS_BITS-1:0]  pos_next;
    logic [POS_BITS-1:0]  pos_inc;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] line_next;
    logic [LINE_BITS-1:0] line_sat_inc;
    logic                 cr_reg;
    logic                 cr_next;
    logic                 can_load;
    logic                 take;
    logic                 do_char;
    logic                 is_lf;
    logic                 mark;
    logic [63:0]          mark_pos_wide;
    logic [63:0]          line_wide;

    logic [utf8lt_pkg::CP_W-1:0] cp_reg;
    logic                        end_reg;
    logic                        lsv_reg;
    logic [31:0]                 lsp_reg;
    logic [31:0]                 lsn_reg;
    logic                        last_reg;

    assign can_load = !out_valid_reg || !out_stall;
    assign take     = can_load && !q_empty;
    assign do_char  = take && head.has_char && !phase_reg;
    assign pop      = take && !(do_char && head.has_end);

    // Line start detection for the character at the head
    assign is_lf         = (head.codepoint == utf8lt_pkg::CP_LF);
    assign mark          = is_lf || cr_reg;
    assign pos_inc       = pos_reg + {{(POS_BITS-1){1'b0}}, 1'b1};
    assign mark_pos_wide = is_lf ? 64'(pos_inc) : 64'(pos_reg);
    assign line_wide     = 64'(line_reg);
    assign line_sat_inc  = (line_reg != {LINE_BITS{1'b1}}) ?
                           line_reg + {{(LINE_BITS-1){1'b1 & 1'b0}}, 1'b1} : line_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        line_next      = line_reg;
        cr_next        = cr_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (do_char)
            begin
                pos_next   = pos_inc;
                cr_next    = !is_lf && (head.codepoint == utf8lt_pkg::CP_CR);
                phase_next = head.has_end;
                if (mark)
                begin
                    line_next = line_sat_inc;
                end
            end
            else
            begin
                phase_next = 1'b0;
            end
        end
        else if (can_load)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_load)
        begin
            line_next = LINE_BITS'(cfg_first_line);
        end
    end

    // Hold tracking state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            pos_reg       <= '0;
            line_reg      <= LINE_BITS'(utf8lt_pkg::FIRST_LINE_RESET);
            cr_reg        <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            line_reg      <= line_next;
            cr_reg        <= cr_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (do_char)
            begin
                cp_reg   <= head.codepoint;
                end_reg  <= 1'b0;
                lsv_reg  <= mark;
                lsp_reg  <= mark ? mark_pos_wide[31:0] : 32'd0;
                lsn_reg  <= mark ? line_wide[31:0] : 32'd0;
                last_reg <= !head.has_end;
            end
            else
            begin
                cp_reg   <= utf8lt_pkg::CP_END;
                end_reg  <= 1'b1;
                lsv_reg  <= 1'b0;
                lsp_reg  <= 32'd0;
                lsn_reg  <= 32'd0;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign codepoint         = cp_reg;
    assign is_end            = end_reg;
    assign line_start_valid  = lsv_reg;
    assign line_start_pos    = lsp_reg;
    assign line_start_number = lsn_reg;
    assign last              = last_reg;

`ifndef NO_ASSERTIONS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_reg |-> last_reg && !lsv_reg)
        else $error("end marker without last or with a line start");
    a_not_last_is_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> !end_reg)
        else $error("non-final result is an end marker");
    a_phase_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !q_empty && head.has_end)
        else $error("second result pending without its request at the head");
`endif

endmodule

[sv/utf8_decoder_line_tracker.sv]
// An accepted byte that completes a character is written to the request queue, and the
//   tracker then loads it from the queue head into the registered outputs.
// Throughput: one byte per cycle while the queue is not full; an end item inside a
//   sequence gives two results and stays at the queue head until the end marker is loaded.
// The four-entry request queue sets how far input runs ahead of a stalled output.
// Reset clears decode and tracking state, first_line returns to 1; no clearing pass.
module utf8_decoder_line_tracker
#(
    parameter int unsigned POS_BITS  = 32,
    parameter int unsigned LINE_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_input,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [utf8lt_pkg::CP_W-1:0] codepoint,
    output logic                        is_end,
    output logic                        line_start_valid,
    output logic [31:0]                 line_start_pos,
    output logic [31:0]                 line_start_number,
    output logic                        last
);

    utf8lt_pkg::q_entry_t push_entry;
    utf8lt_pkg::q_entry_t head;
    logic                 push;
    logic                 pop;
    logic                 q_empty;
    logic                 q_full;
    logic                 cfg_load;
    logic [15:0]          first_line_reg;

    // Register write and read decode
    assign pready   = 1'b1;
    assign cfg_load = psel && penable && pwrite && (paddr[2] == utf8lt_pkg::REG_FIRST_LINE);
    assign prdata   = (paddr[2] == utf8lt_pkg::REG_FIRST_LINE) ? {16'd0, first_line_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg <= utf8lt_pkg::FIRST_LINE_RESET;
        end
        else if (cfg_load)
        begin
            first_line_reg <= pwdata[15:0];
        end
    end

    assign in_stall = q_full;

    utf8lt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .q_full       (q_full),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .push         (push),
        .push_entry   (push_entry)
    );

    utf8lt_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    utf8lt_back
    #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .q_empty           (q_empty),
        .pop               (pop),
        .cfg_load          (cfg_load),
        .cfg_first_line    (pwdata[15:0]),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .codepoint         (codepoint),
        .is_end            (is_end),
        .line_start_valid  (line_start_valid),
        .line_start_pos    (line_start_pos),
        .line_start_number (line_start_number),
        .last              (last)
    );

endmodule
